// ===== hw/rtl/glmd_pkg.sv =====
// shared types, constants and helpers for the grid local maxima detector
// no dependencies; imported by every glmd module
`default_nettype none

package glmd_pkg;

  // grid geometry limits
  localparam int ROW_LIMIT       = 1024;
  localparam int COORD_W         = 10;
  localparam int CFG_W           = 11;
  localparam int CFG_IDX_W       = 2;

  // parameter defaults
  localparam int MAX_COLS_DEF    = 1024;
  localparam int VALUE_WIDTH_DEF = 16;

  // result queue geometry
  localparam int Q_DEPTH         = 4;
  localparam int Q_PTR_W         = 2;
  localparam int Q_CNT_W         = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_COLS = 2'd1;

  // bit positions of the hit mask, in delivery order
  localparam int HIT_ABOVE = 0;  // cell above the input
  localparam int HIT_LEFT  = 1;  // last-row cell left of the input
  localparam int HIT_SELF  = 2;  // the input itself, when it ends the last row
  localparam int HIT_W     = 3;

  // one classified input with at least one local maximum
  typedef struct packed {
    logic [HIT_W-1:0]   hits;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } peak_entry_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // register value to index of the last row or column, zero acts as one,
  // values above the limit saturate
  function automatic logic [COORD_W-1:0] clamp_last(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] lim);
    logic [CFG_W-1:0] t;
    if (v == '0) begin
      t = '0;
    end else if (v > lim) begin
      t = lim - CFG_W'(1);
    end else begin
      t = v - CFG_W'(1);
    end
    return t[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/glmd_front.sv =====
// front part: raster counters, two row memories and the classify stage
// depends on glmd_pkg
`default_nettype none

module glmd_front #(
  parameter int MAX_COLS    = glmd_pkg::MAX_COLS_DEF,
  parameter int VALUE_WIDTH = glmd_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [glmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [glmd_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [VALUE_WIDTH-1:0]      in_cell_value,
  input  wire glmd_pkg::q_status_t                q_status,
  output logic                                    q_push,
  output glmd_pkg::peak_entry_t                   q_entry
);
  import glmd_pkg::*;

  localparam int AW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int COL_LIMIT = (MAX_COLS < ROW_LIMIT) ? MAX_COLS : ROW_LIMIT;
  localparam logic [CFG_W-1:0] COL_LIM = CFG_W'(COL_LIMIT);
  localparam logic [CFG_W-1:0] ROW_LIM = CFG_W'(ROW_LIMIT);

  // grid size and raster position
  logic [COORD_W-1:0] rows_last_r, cols_last_r;
  logic [COORD_W-1:0] row_r, row_nxt, col_r, col_nxt;

  // row memories
  logic signed [VALUE_WIDTH-1:0] prev_mem [MAX_COLS];
  logic signed [VALUE_WIDTH-1:0] older_mem [MAX_COLS];
  logic signed [VALUE_WIDTH-1:0] rd_prev_r, rd_older_r;

  // classify stage
  logic                          s1_valid_r;
  logic signed [VALUE_WIDTH-1:0] s1_cur_r, s1_up_r, s1_left0_r, s1_left1_r, s1_left2_r;
  logic [COORD_W-1:0]            s1_row_r, s1_col_r;
  logic                          s1_r_ge1_r, s1_r_ge2_r, s1_c_gt0_r, s1_c_ge2_r;
  logic                          s1_c_end_r, s1_r_end_r;

  logic                          accept;
  logic                          c_last, r_last;
  logic [COORD_W-1:0]            col_inc;
  logic [AW-1:0]                 wr_addr, rd_addr;
  logic signed [VALUE_WIDTH-1:0] up_in;
  logic [HIT_W-1:0]              hits;
  logic                          s1_go;
  logic                          ok_above, ok_left, ok_self;

  assign accept  = in_valid && in_ready;
  assign c_last  = (col_r == cols_last_r);
  assign r_last  = (row_r == rows_last_r);
  assign col_inc = col_r + COORD_W'(1);
  assign wr_addr = AW'(col_r);
  assign rd_addr = c_last ? '0 : AW'(col_inc);
  // a one-column grid reads its own row back, taken from the stage register
  assign up_in   = (cols_last_r == '0) ? s1_cur_r : rd_prev_r;

  // next raster position
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (c_last) begin
        col_nxt = '0;
        row_nxt = r_last ? '0 : row_r + COORD_W'(1);
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  // configuration and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_last_r <= '0;
      cols_last_r <= '0;
      row_r       <= '0;
      col_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_GRID_ROWS: begin
          rows_last_r <= clamp_last(cfg_wdata, ROW_LIM);
          row_r       <= '0;
          col_r       <= '0;
        end
        CFG_IDX_GRID_COLS: begin
          cols_last_r <= clamp_last(cfg_wdata, COL_LIM);
          row_r       <= '0;
          col_r       <= '0;
        end
        default: begin
          row_r <= row_nxt;
          col_r <= col_nxt;
        end
      endcase
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // row memories, read before write at each transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_prev_r          <= prev_mem[rd_addr];
      rd_older_r         <= older_mem[wr_addr];
      prev_mem[wr_addr]  <= in_cell_value;
      if (row_r != '0) begin
        older_mem[wr_addr] <= up_in;
      end
    end
  end

  // classify stage payload and neighbor window
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r   <= in_cell_value;
      s1_up_r    <= up_in;
      s1_left0_r <= s1_up_r;
      s1_left1_r <= s1_cur_r;
      s1_left2_r <= s1_left1_r;
      s1_row_r   <= row_r;
      s1_col_r   <= col_r;
      s1_r_ge1_r <= (row_r != '0);
      s1_r_ge2_r <= (row_r > COORD_W'(1));
      s1_c_gt0_r <= (col_r != '0);
      s1_c_ge2_r <= (col_r > COORD_W'(1));
      s1_c_end_r <= c_last;
      s1_r_end_r <= r_last;
    end
  end

  // neighbor compares
  always_comb begin
    ok_above = s1_r_ge1_r && (s1_up_r >= s1_cur_r)
               && (!s1_r_ge2_r || (s1_up_r >= rd_older_r))
               && (!s1_c_gt0_r || (s1_up_r >= s1_left0_r))
               && (s1_c_end_r || (s1_up_r >= rd_prev_r));
    ok_left  = s1_r_end_r && s1_c_gt0_r && (s1_left1_r >= s1_cur_r)
               && (!s1_c_ge2_r || (s1_left1_r >= s1_left2_r))
               && (!s1_r_ge1_r || (s1_left1_r >= s1_left0_r));
    ok_self  = s1_r_end_r && s1_c_end_r
               && (!s1_c_gt0_r || (s1_cur_r >= s1_left1_r))
               && (!s1_r_ge1_r || (s1_cur_r >= s1_up_r));
    hits            = '0;
    hits[HIT_ABOVE] = ok_above;
    hits[HIT_LEFT]  = ok_left;
    hits[HIT_SELF]  = ok_self;
  end

  assign s1_go    = s1_valid_r && ((hits == '0) || !q_status.full);
  assign in_ready = !s1_valid_r || s1_go;
  assign q_push   = s1_go && (hits != '0);

  always_comb begin
    q_entry.hits = hits;
    q_entry.row  = s1_row_r;
    q_entry.col  = s1_col_r;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/glmd_queue.sv =====
// short queue of classified entries between front and back
// depends on glmd_pkg
`default_nettype none

module glmd_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire glmd_pkg::peak_entry_t  push_entry,
  input  wire logic                   pop,
  output glmd_pkg::peak_entry_t       head_entry,
  output glmd_pkg::q_status_t         status
);
  import glmd_pkg::*;

  peak_entry_t        mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign status.full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign status.not_empty = (cnt_r != '0);
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;
  assign head_entry       = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/glmd_back.sv =====
// back part: turns each queued hit mask into result transfers, one per ready cycle
// depends on glmd_pkg
`default_nettype none

module glmd_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire glmd_pkg::peak_entry_t        head_entry,
  input  wire glmd_pkg::q_status_t          q_status,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [glmd_pkg::COORD_W-1:0]      out_peak_row,
  output logic [glmd_pkg::COORD_W-1:0]      out_peak_col,
  output logic                              out_last_of_run
);
  import glmd_pkg::*;

  logic               out_valid_r;
  logic [COORD_W-1:0] row_r, col_r;
  logic               last_r;
  logic [HIT_W-1:0]   done_r;

  logic [HIT_W-1:0]   rem, sel, after;
  logic               load;
  logic [COORD_W-1:0] sel_row, sel_col;

  assign rem  = head_entry.hits & ~done_r;
  assign load = q_status.not_empty && (!out_valid_r || out_ready);

  // pick the next hit in delivery order
  always_comb begin
    sel     = '0;
    sel_row = head_entry.row;
    sel_col = head_entry.col;
    priority if (rem[HIT_ABOVE]) begin
      sel[HIT_ABOVE] = 1'b1;
      sel_row        = head_entry.row - COORD_W'(1);
    end else if (rem[HIT_LEFT]) begin
      sel[HIT_LEFT]  = 1'b1;
      sel_col        = head_entry.col - COORD_W'(1);
    end else begin
      sel[HIT_SELF]  = 1'b1;
    end
  end

  assign after = rem & ~sel;
  assign pop   = load && (after == '0);

  // output register and progress through the head entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        done_r      <= (after == '0) ? '0 : (done_r | sel);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_r  <= sel_row;
      col_r  <= sel_col;
      last_r <= (after == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_peak_row    = row_r;
  assign out_peak_col    = col_r;
  assign out_last_of_run = last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/grid_local_maxima_detect_unit.sv =====
// top level of the grid local maxima detector; depends on glmd_pkg, glmd_front,
//   glmd_queue and glmd_back
// a result passes the classify stage register, a 4-entry queue and the output register
// throughput: one input per cycle unless the queue is full; each row memory does a read
//   and a write per item; a last-row input gives up to three results, one per ready cycle
// reset: counters cleared, grid size 1 x 1, queue and output empty; row memories uncleared
`default_nettype none

module grid_local_maxima_detect_unit #(
  parameter int MAX_COLS    = glmd_pkg::MAX_COLS_DEF,
  parameter int VALUE_WIDTH = glmd_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [glmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [glmd_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [VALUE_WIDTH-1:0]      in_cell_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [glmd_pkg::COORD_W-1:0]            out_peak_row,
  output logic [glmd_pkg::COORD_W-1:0]            out_peak_col,
  output logic                                    out_last_of_run
);
  import glmd_pkg::*;

  q_status_t   q_status;
  peak_entry_t push_entry, head_entry;
  logic        q_push, q_pop;

  // accept and classify
  glmd_front #(
    .MAX_COLS    (MAX_COLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cell_value (in_cell_value),
    .q_status      (q_status),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  // decoupling queue
  glmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head_entry (head_entry),
    .status     (q_status)
  );

  // result delivery
  glmd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_entry      (head_entry),
    .q_status        (q_status),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_peak_row    (out_peak_row),
    .out_peak_col    (out_peak_col),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for grid_local_maxima_detect_unit: streams grids under
// random idling and back-pressure, predicts every peak and compares each transfer
// depends on glmd_pkg and the detector rtl only

// one expected peak report
typedef struct {
  logic [glmd_pkg::COORD_W-1:0] row;
  logic [glmd_pkg::COORD_W-1:0] col;
  logic                         last;
} peak_t;

// peak predictor and store of outstanding peak reports
class peak_scoreboard;
  localparam int DEPTH = glmd_pkg::MAX_COLS_DEF;

  logic signed [glmd_pkg::VALUE_WIDTH_DEF-1:0] older_row [DEPTH];
  logic signed [glmd_pkg::VALUE_WIDTH_DEF-1:0] prev_row [DEPTH];
  logic signed [glmd_pkg::VALUE_WIDTH_DEF-1:0] left_above;
  logic signed [glmd_pkg::VALUE_WIDTH_DEF-1:0] left_cur;
  logic [glmd_pkg::CFG_W-1:0] rows_reg;
  logic [glmd_pkg::CFG_W-1:0] cols_reg;
  int unsigned row_pos;
  int unsigned col_pos;
  peak_t pending[$];
  int errors;
  int checked;
  int cells;

  function new();
    foreach (older_row[i]) begin
      older_row[i] = '0;
      prev_row[i] = '0;
    end
    left_above = '0;
    left_cur = '0;
    rows_reg = glmd_pkg::CFG_W'(1);
    cols_reg = glmd_pkg::CFG_W'(1);
    row_pos = 0;
    col_pos = 0;
    errors = 0;
    checked = 0;
    cells = 0;
  endfunction

  // register value to grid extent: zero acts as one, large values saturate
  static function int unsigned span(logic [glmd_pkg::CFG_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function void note_config(logic [glmd_pkg::CFG_IDX_W-1:0] idx,
                            logic [glmd_pkg::CFG_W-1:0] data);
    if (idx == glmd_pkg::CFG_IDX_GRID_ROWS) begin
      rows_reg = data;
    end else if (idx == glmd_pkg::CFG_IDX_GRID_COLS) begin
      cols_reg = data;
    end else begin
      return;
    end
    row_pos = 0;
    col_pos = 0;
  endfunction

  // decide every cell whose last neighbor is this input
  function void note_input(logic signed [glmd_pkg::VALUE_WIDTH_DEF-1:0] cur);
    int unsigned nr, nc, r, c;
    logic signed [glmd_pkg::VALUE_WIDTH_DEF-1:0] above, ctr;
    bit ok;
    peak_t found[$];
    nr = span(rows_reg, glmd_pkg::ROW_LIMIT);
    nc = span(cols_reg, DEPTH);
    if (nc > glmd_pkg::ROW_LIMIT) nc = glmd_pkg::ROW_LIMIT;
    r = row_pos;
    c = col_pos;
    cells++;
    if (r >= nr || c >= nc) begin
      r = 0;
      c = 0;
    end
    above = prev_row[c];
    // cell above the input
    if (r >= 1) begin
      ok = above >= cur;
      if (r >= 2 && above < older_row[c]) ok = 0;
      if (c > 0 && above < left_above) ok = 0;
      if (c + 1 < nc && above < prev_row[c + 1]) ok = 0;
      if (ok) found.push_back('{row: glmd_pkg::COORD_W'(r - 1),
                                col: glmd_pkg::COORD_W'(c), last: 1'b0});
    end
    // last row: the cell to the left, then the input itself at row end
    if (r == nr - 1) begin
      if (c > 0) begin
        ctr = left_cur;
        ok = ctr >= cur;
        if (c >= 2 && ctr < prev_row[c - 2]) ok = 0;
        if (r >= 1 && ctr < left_above) ok = 0;
        if (ok) found.push_back('{row: glmd_pkg::COORD_W'(r),
                                  col: glmd_pkg::COORD_W'(c - 1), last: 1'b0});
      end
      if (c == nc - 1) begin
        ok = 1;
        if (c > 0 && cur < left_cur) ok = 0;
        if (r >= 1 && cur < above) ok = 0;
        if (ok) found.push_back('{row: glmd_pkg::COORD_W'(r),
                                  col: glmd_pkg::COORD_W'(c), last: 1'b0});
      end
    end
    foreach (found[i]) begin
      found[i].last = (i == found.size() - 1);
      pending.push_back(found[i]);
    end
    // shift the line stores and advance the raster position
    if (r >= 1) older_row[c] = above;
    left_above = above;
    prev_row[c] = cur;
    left_cur = cur;
    c++;
    if (c >= nc) begin
      c = 0;
      r++;
      if (r >= nr) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  function void check_peak(logic [glmd_pkg::COORD_W-1:0] row,
                           logic [glmd_pkg::COORD_W-1:0] col, logic last);
    peak_t want;
    if (pending.size() == 0) begin
      $error("peak at row %0d col %0d with none expected", row, col);
      errors++;
      return;
    end
    want = pending.pop_front();
    checked++;
    if (row !== want.row) begin
      $error("peak_row: expected %0d, got %0d", want.row, row);
      errors++;
    end
    if (col !== want.col) begin
      $error("peak_col: expected %0d, got %0d", want.col, col);
      errors++;
    end
    if (last !== want.last) begin
      $error("last_of_run: expected %0d, got %0d", want.last, last);
      errors++;
    end
  endfunction
endclass

module testbench;
  import glmd_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam int RANDOM_CELLS = 440;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  // index with no register behind it, writes there are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef enum {FILL_NARROW, FILL_FULL, FILL_PLATEAU, FILL_EXTREME} fill_style_t;
  typedef enum {READY_ALWAYS, READY_COIN, READY_ONE_IN_FOUR, READY_MOSTLY} ready_style_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [VW-1:0] in_cell_value;
  logic                 out_valid;
  logic                 out_ready;
  logic [COORD_W-1:0]   out_peak_row;
  logic [COORD_W-1:0]   out_peak_col;
  logic                 out_last_of_run;

  peak_scoreboard board;
  bit hold_req = 1'b0;
  int burst_left = 0;
  int input_stalls = 0;

  grid_local_maxima_detect_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cell_value   (in_cell_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_peak_row    (out_peak_row),
    .out_peak_col    (out_peak_col),
    .out_last_of_run (out_last_of_run)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result monitor, also counts input back-pressure
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_peak(out_peak_row, out_peak_col, out_last_of_run);
    end
    if (rst_n && in_valid && !in_ready) input_stalls++;
  end

  // receiver: changing ready patterns, plus a long hold on request
  initial begin : receiver
    ready_style_t mode;
    int tick;
    out_ready <= 1'b0;
    mode = READY_ALWAYS;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (tick % 50 == 0) mode = ready_style_t'($urandom_range(0, 3));
        tick++;
        unique case (mode)
          READY_ALWAYS:      out_ready <= 1'b1;
          READY_COIN:        out_ready <= 1'($urandom_range(0, 1));
          READY_ONE_IN_FOUR: out_ready <= (tick % 4 == 0);
          default:           out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // watchdog: ends the run after a long stretch with no transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // single register write, with cfg_we lowered again before the task returns
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.note_config(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    write_reg(CFG_IDX_GRID_ROWS, rows);
    write_reg(CFG_IDX_GRID_COLS, cols);
  endtask

  // one cell transfer, sent in bursts with random gaps between them
  task automatic feed_cell(input logic signed [VW-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_cell_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(v);
    burst_left--;
  endtask

  // stop sending, wait for every expected peak, then let the pipeline settle
  task automatic finish_phase();
    in_valid <= 1'b0;
    burst_left = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_extent(input int unsigned typical);
    unique case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'(ROW_LIMIT);
      2:       return CFG_W'($urandom);
      3:       return '1;
      default: return CFG_W'($urandom_range(1, typical));
    endcase
  endfunction

  function automatic logic signed [VW-1:0] pick_value(input fill_style_t style,
                                                      input logic signed [VW-1:0] base);
    unique case (style)
      FILL_NARROW:  return VW'($urandom_range(0, 4)) - VW'(2);
      FILL_FULL:    return VW'($urandom);
      FILL_PLATEAU: return ($urandom_range(0, 5) == 0) ? base + VW'($urandom_range(0, 2)) - VW'(1)
                                                       : base;
      default: begin
        unique case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // stimulus
  initial begin : stimulus
    logic signed [VW-1:0] vals[$];
    logic [CFG_W-1:0] rows, cols;
    logic signed [VW-1:0] base;
    fill_style_t style;
    int unsigned area, n;
    int random_cells, settings;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_cell_value <= '0;
    board = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settings = 0;

    // zero sizes act as a 1 x 1 grid, each cell is its own peak
    set_grid('0, '0);
    feed_cell(16'sh8000);
    feed_cell(16'sh7fff);
    finish_phase();
    settings++;

    // 3 x 3 with extremes and ties, unused index written mid grid leaves it running
    set_grid(CFG_W'(3), CFG_W'(3));
    vals = '{16'sh7fff, 16'sh8000, 16'sd5, 16'sd5};
    foreach (vals[i]) feed_cell(vals[i]);
    finish_phase();
    write_reg(CFG_IDX_UNUSED, '1);
    vals = '{16'sd5, 16'sd5, 16'sh8000, 16'sh7fff, 16'sd0};
    foreach (vals[i]) feed_cell(vals[i]);
    finish_phase();
    settings++;

    // oversized values saturate, partial grid dropped by the next write
    set_grid('1, '1);
    vals = '{16'sd1, 16'sd2, 16'sd3, 16'sd4};
    foreach (vals[i]) feed_cell(vals[i]);
    finish_phase();
    settings++;

    // single row of ties: every cell peaks, row end decided at once
    set_grid(CFG_W'(1), CFG_W'(4));
    repeat (4) feed_cell(16'sd0);
    finish_phase();
    settings++;

    // single column
    set_grid(CFG_W'(4), CFG_W'(1));
    vals = '{-16'sd1, 16'sd3, 16'sd3, 16'sh8000};
    foreach (vals[i]) feed_cell(vals[i]);
    finish_phase();
    settings++;

    // long output hold while a row of ties keeps the result queue full
    set_grid(CFG_W'(1), CFG_W'(16));
    hold_req = 1'b1;
    repeat (40) feed_cell(16'sd7);
    finish_phase();
    settings++;

    // random grids: mostly small whole grids, large ones only in part
    random_cells = 0;
    while (random_cells < RANDOM_CELLS) begin
      rows = pick_extent(6);
      cols = pick_extent(10);
      set_grid(rows, cols);
      settings++;
      style = fill_style_t'($urandom_range(0, 3));
      base = VW'($urandom);
      area = board.span(rows, ROW_LIMIT) * board.span(cols, MAX_COLS_DEF);
      if (area <= 64) begin
        n = area * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, area);
      end else begin
        n = $urandom_range(20, 60);
      end
      repeat (n) feed_cell(pick_value(style, base));
      random_cells += n;
      finish_phase();
    end

    $display("summary: %0d cells over %0d grid settings, %0d peaks checked",
             board.cells, settings, board.checked);
    $display("summary: input back-pressured on %0d cycles, one output hold of %0d cycles",
             input_stalls, HOLD_CYCLES);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
